FILE: src/ordered_multiset_successor_top_defines.svh
// Assertion macros for the ordered multiset block.
// Used by ordered_multiset_successor_top; depends on clk_i and rst_ni in scope.
`ifndef ORDERED_MULTISET_SUCCESSOR_TOP_DEFINES_SVH
`define ORDERED_MULTISET_SUCCESSOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ORDMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ORDMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ORDMS_ASSERT_IMP(lbl, ante, cons, msg)
`define ORDMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/ordms_pkg.sv
// Shared types and constants of the ordered multiset block.
// No dependencies; imported by ordms_cell, ordered_multiset_successor_top and the testbench.
package ordms_pkg;

  localparam int unsigned KeyW = 31;
  localparam int unsigned OccW = 9;
  localparam logic [KeyW-1:0] NoneKey = 31'h7fffffff;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } stat_e;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CMP   = 2'd1,
    PH_APPLY = 2'd2
  } phase_e;

  // Control broadcast to every cell.
  typedef struct packed {
    logic            cmp_en;
    logic            ins_en;
    logic            del_en;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

  // Comparison flags registered in each cell.
  typedef struct packed {
    logic past;      // empty or holds a key above the request key
    logic ge;        // holds a key at or above the request key
    logic eq;        // holds the request key
    logic first_gt;  // first cell holding a key above the request key
  } cell_flag_t;

endpackage

FILE: src/ordms_cell.sv
// One cell of the sorted key chain: a key, its valid bit and comparison flags.
// Depends on ordms_pkg.
module ordms_cell import ordms_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0] left_key_i,
  input  logic            left_valid_i,
  input  logic            left_gt_i,
  input  cell_flag_t      left_flag_i,
  input  logic [KeyW-1:0] right_key_i,
  input  logic            right_valid_i,
  output logic [KeyW-1:0] key_o,
  output logic            valid_o,
  output logic            gt_o,
  output cell_flag_t      flag_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic            valid_q, valid_d;
  cell_flag_t      flag_q, flag_d;
  logic            gt;

  // Compare the stored key against the request key.
  assign gt = valid_q && (key_q > ctrl_i.key);

  always_comb begin
    flag_d.past     = !valid_q || (key_q > ctrl_i.key);
    flag_d.ge       = valid_q && (key_q >= ctrl_i.key);
    flag_d.eq       = valid_q && (key_q == ctrl_i.key);
    flag_d.first_gt = gt && !left_gt_i;
  end

  // Insert shifts the tail right, delete shifts it left.
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.ins_en && flag_q.past) begin
      if (left_flag_i.past) begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end else begin
        key_d   = ctrl_i.key;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.del_en && flag_q.ge) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        flag_q <= flag_d;
      end
    end
  end

  // The key itself needs no reset: an invalid cell's key is never used.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;
  assign flag_o  = flag_q;

endmodule

FILE: src/ordered_multiset_successor_top.sv
// Top level of the ordered multiset with successor query.
// Depends on ordms_pkg, ordms_cell and ordered_multiset_successor_top_defines.svh.
//
//   channel   direction   handshake                 payload
//   request   in          in_valid_i / in_ready_o   command_i, key_value_i
//   result    out         out_valid_o / out_ready_i status_o, found_o, result_key_o,
//                                                   occupancy_o
//
// Each request passes the phases PH_CMP, in which every cell compares its key,
// and PH_APPLY, in which the cells shift and the result register is loaded.
// The one-hot successor select over the whole chain lies in the PH_APPLY path.
// A result waiting in the output register stalls the shift cycle only.
// Reset empties the store at once; no clearing pass follows.
`include "ordered_multiset_successor_top_defines.svh"
module ordered_multiset_successor_top import ordms_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [KeyW-1:0] key_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic            found_o,
  output logic [KeyW-1:0] result_key_o,
  output logic [OccW-1:0] occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  phase_e          phase_q, phase_d;
  cmd_e            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  logic            found_q, found_d;
  logic [KeyW-1:0] rkey_q, rkey_d;
  logic            in_fire, out_free, apply_fire, full;
  logic            any_gt, any_eq;
  logic [KeyW-1:0] sel_key;
  logic [CntW+OccW-1:0] count_ext;
  cell_ctrl_t      ctrl;

  logic [KeyW-1:0] cell_key   [CAPACITY];
  logic            cell_valid [CAPACITY];
  logic            cell_gt    [CAPACITY];
  cell_flag_t      cell_flag  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, first_vec;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;
  assign full     = (count_q == CntW'(CAPACITY));

  // Sequencer next state.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:  if (in_valid_i) phase_d = PH_CMP;
      PH_CMP:   phase_d = PH_APPLY;
      PH_APPLY: if (out_free) phase_d = in_valid_i ? PH_CMP : PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    apply_fire = 1'b0;
    unique case (phase_q)
      PH_IDLE:  in_ready_o = 1'b1;
      PH_CMP:   in_ready_o = 1'b0;
      PH_APPLY: begin
        in_ready_o = out_free;
        apply_fire = out_free;
      end
      default:  in_ready_o = 1'b0;
    endcase
  end

  // Control broadcast to the cell chain.
  always_comb begin
    ctrl.cmp_en = (phase_q == PH_CMP);
    ctrl.ins_en = apply_fire && (cmd_q == CMD_INSERT) && !full;
    ctrl.del_en = apply_fire && (cmd_q == CMD_DELETE) && any_eq;
    ctrl.key    = key_q;
  end

  // The cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] l_key, r_key;
    logic            l_valid, l_gt, r_valid;
    cell_flag_t      l_flag;
    if (i == 0) begin : g_head
      assign l_key   = '0;
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
      assign l_flag  = '0;
    end else begin : g_link_l
      assign l_key   = cell_key[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_flag  = cell_flag[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_link_r
      assign r_key   = cell_key[i+1];
      assign r_valid = cell_valid[i+1];
    end
    ordms_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_key_i    (l_key),
      .left_valid_i  (l_valid),
      .left_gt_i     (l_gt),
      .left_flag_i   (l_flag),
      .right_key_i   (r_key),
      .right_valid_i (r_valid),
      .key_o         (cell_key[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i]),
      .flag_o        (cell_flag[i])
    );
    assign valid_vec[i] = cell_valid[i];
    assign first_vec[i] = cell_flag[i].first_gt;
  end

  // One-hot successor select and delete hit over the registered flags.
  always_comb begin
    any_gt  = 1'b0;
    any_eq  = 1'b0;
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_gt  = any_gt | cell_flag[i].first_gt;
      any_eq  = any_eq | cell_flag[i].eq;
      sel_key = sel_key | (cell_key[i] & {KeyW{cell_flag[i].first_gt}});
    end
  end

  // Result of the request in the shift cycle.
  always_comb begin
    status_d = STAT_OK;
    found_d  = 1'b0;
    rkey_d   = NoneKey;
    count_d  = count_q;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) status_d = STAT_FULL;
        else      count_d  = count_q + CntW'(1);
      end
      CMD_DELETE: begin
        if (any_eq) count_d  = count_q - CntW'(1);
        else        status_d = STAT_ABSENT;
      end
      CMD_QUERY: begin
        found_d = any_gt;
        if (any_gt) rkey_d = sel_key;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (apply_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_value_i;
    end
    if (apply_fire) begin
      status_q <= status_d;
      found_q  <= found_d;
      rkey_q   <= rkey_d;
    end
  end

  assign count_ext    = {{OccW{1'b0}}, count_q};
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign result_key_o = rkey_q;
  assign occupancy_o  = count_ext[OccW-1:0];

  // Checks on the chain and the sequencer.
  `ORDMS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `ORDMS_ASSERT_IMP(a_first_onehot, phase_q == PH_APPLY, $onehot0(first_vec), "successor not unique")
  `ORDMS_ASSERT_IMP(a_valid_count, phase_q == PH_IDLE, $countones(valid_vec) == count_q, "valid bits disagree with count")
  `ORDMS_ASSERT_NXT(a_accept_cmp, in_valid_i && in_ready_o, phase_q == PH_CMP, "accepted request not compared")

endmodule

FILE: sim/ordered_multiset_successor_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ordered_multiset_successor_top.
// Depends on ordms_pkg and the block's RTL; a built-in sorted-store predictor checks results.
module ordered_multiset_successor_top_test;
  import ordms_pkg::*;

  localparam int unsigned CAPACITY = 256;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 700;
  localparam int TAIL_CYCLES = 8;
  localparam int OPENING_ROWS = 18;

  // One expected result of a request.
  typedef struct packed {
    stat_e           status;
    logic            found;
    logic [KeyW-1:0] result_key;
    logic [OccW-1:0] occupancy;
  } outcome_t;

  // One row of the opening table; fixed rows carry a result read off by hand.
  typedef struct packed {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
    logic            fixed;
    outcome_t        want;
  } stim_row_t;

  localparam outcome_t PREDICTED = '{STAT_OK, 1'b0, NoneKey, '0};

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            req_valid = 1'b0;
  logic            req_ready;
  logic [1:0]      req_command = CMD_NOP;
  logic [KeyW-1:0] req_key = '0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  logic [1:0]      res_status;
  logic            res_found;
  logic [KeyW-1:0] res_key;
  logic [OccW-1:0] res_occ;

  // Predictor state: the stored keys in ascending order.
  logic [KeyW-1:0] store_keys[$];
  outcome_t        expected_q[$];
  stim_row_t       opening_rows [OPENING_ROWS];

  int mismatches = 0;
  int results_seen = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int full_drops = 0;
  int absent_deletes = 0;
  int query_hits = 0;
  int peak_occ = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  ordered_multiset_successor_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .command_i    (req_command),
    .key_value_i  (req_key),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .status_o     (res_status),
    .found_o      (res_found),
    .result_key_o (res_key),
    .occupancy_o  (res_occ)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one request to the sorted store and returns the result it gives.
  function automatic outcome_t apply_request(cmd_e cmd, logic [KeyW-1:0] key);
    outcome_t o;
    int pos;
    o = PREDICTED;
    pos = 0;
    case (cmd)
      CMD_INSERT: begin
        if (store_keys.size() >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          // A duplicate lands after the equal keys already stored.
          while (pos < store_keys.size() && store_keys[pos] <= key) pos++;
          store_keys.insert(pos, key);
        end
      end
      CMD_DELETE: begin
        while (pos < store_keys.size() && store_keys[pos] != key) pos++;
        if (pos == store_keys.size()) o.status = STAT_ABSENT;
        else store_keys.delete(pos);
      end
      CMD_QUERY: begin
        while (pos < store_keys.size() && store_keys[pos] <= key) pos++;
        if (pos < store_keys.size()) begin
          o.found = 1'b1;
          o.result_key = store_keys[pos];
        end
      end
      default: ;
    endcase
    o.occupancy = OccW'(store_keys.size());
    return o;
  endfunction

  // Picks a key: often a stored one or its neighbour, else small, extreme or any value.
  function automatic logic [KeyW-1:0] pick_key(int hit_pct);
    logic [KeyW-1:0] k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < hit_pct && store_keys.size() != 0) begin
      k = store_keys[$urandom_range(0, store_keys.size() - 1)];
      if ($urandom_range(0, 3) == 0) k = k + KeyW'($urandom_range(0, 2)) - KeyW'(1);
    end else if (sel < hit_pct + (100 - hit_pct) / 2) begin
      k = KeyW'($urandom_range(0, 63));
    end else if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = KeyW'(1);
        2: k = NoneKey - KeyW'(1);
        default: k = NoneKey;
      endcase
    end else begin
      k = KeyW'($urandom);
    end
    return k;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 60) begin
      $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    end
  endtask

  // Offers one request and holds it until the block takes it, then books the expectation.
  task automatic send_request(cmd_e cmd, logic [KeyW-1:0] key, logic fixed, outcome_t want);
    outcome_t o;
    req_valid <= 1'b1;
    req_command <= cmd;
    req_key <= key;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    o = apply_request(cmd, key);
    cmd_count[cmd]++;
    if (o.status == STAT_FULL) full_drops++;
    if (o.status == STAT_ABSENT) absent_deletes++;
    if (o.found) query_hits++;
    if (int'(o.occupancy) > peak_occ) peak_occ = int'(o.occupancy);
    expected_q.push_back(fixed ? want : o);
  endtask

  // Sender idling: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 100);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // One random phase with the given percentages of inserts, deletes and queries.
  task automatic run_phase(int count, int w_ins, int w_del, int w_qry);
    cmd_e cmd;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) cmd = CMD_INSERT;
      else if (r < w_ins + w_del) cmd = CMD_DELETE;
      else if (r < w_ins + w_del + w_qry) cmd = CMD_QUERY;
      else cmd = CMD_NOP;
      pace_sender();
      send_request(cmd, pick_key(cmd == CMD_DELETE ? 75 : 40), 1'b0, PREDICTED);
    end
    // Let the block drain completely before the next phase.
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Result checking against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && res_valid && res_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (res_status !== want.status) report_mismatch("status", res_status, want.status);
        if (res_found !== want.found) report_mismatch("found", res_found, want.found);
        if (res_key !== want.result_key) report_mismatch("result_key", res_key, want.result_key);
        if (res_occ !== want.occupancy) report_mismatch("occupancy", res_occ, want.occupancy);
      end
    end
  end

  // Receiver stalls: stretches of differing ready patterns, plus one long hold-off.
  initial begin : result_drain
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        case (mode)
          0: res_ready <= 1'b1;
          1: res_ready <= 1'($urandom_range(0, 1));
          2: res_ready <= ($urandom_range(0, 3) == 0);
          default: res_ready <= (tick % 5 != 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin : idle_watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("[ordered_multiset_successor_top] ERROR");
    $finish;
  end

  // Stimulus: opening table, then random phases, then the final drain.
  initial begin : stimulus
    opening_rows = '{
      '{CMD_QUERY,  31'd0,          1'b1, '{STAT_OK,     1'b0, NoneKey, 9'd0}},
      '{CMD_DELETE, 31'd5,          1'b1, '{STAT_ABSENT, 1'b0, NoneKey, 9'd0}},
      '{CMD_NOP,    NoneKey,        1'b1, '{STAT_OK,     1'b0, NoneKey, 9'd0}},
      '{CMD_INSERT, NoneKey,        1'b1, '{STAT_OK,     1'b0, NoneKey, 9'd1}},
      '{CMD_QUERY,  31'h7ffffffe,   1'b1, '{STAT_OK,     1'b1, NoneKey, 9'd1}},
      '{CMD_QUERY,  NoneKey,        1'b1, '{STAT_OK,     1'b0, NoneKey, 9'd1}},
      '{CMD_INSERT, 31'd0,          1'b1, '{STAT_OK,     1'b0, NoneKey, 9'd2}},
      '{CMD_INSERT, 31'd0,          1'b0, PREDICTED},
      '{CMD_INSERT, 31'h55555555,   1'b0, PREDICTED},
      '{CMD_INSERT, 31'h2aaaaaaa,   1'b0, PREDICTED},
      '{CMD_QUERY,  31'd0,          1'b0, PREDICTED},
      '{CMD_DELETE, 31'd0,          1'b0, PREDICTED},
      '{CMD_QUERY,  31'h2aaaaaaa,   1'b0, PREDICTED},
      '{CMD_DELETE, NoneKey,        1'b0, PREDICTED},
      '{CMD_DELETE, NoneKey,        1'b0, PREDICTED},
      '{CMD_NOP,    31'h55555555,   1'b0, PREDICTED},
      '{CMD_DELETE, 31'h2aaaaaaa,   1'b0, PREDICTED},
      '{CMD_QUERY,  31'd0,          1'b0, PREDICTED}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table: extremes, every command and the flagged cases.
    for (int n = 0; n < OPENING_ROWS; n++) begin
      send_request(opening_rows[n].cmd, opening_rows[n].key, opening_rows[n].fixed,
                   opening_rows[n].want);
    end
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    // Fill past capacity, churn while full, drain past empty, then mixed traffic.
    run_phase(520, 76, 8, 12);
    run_phase(300, 40, 40, 16);
    run_phase(480, 8, 78, 12);
    run_phase(350, 35, 30, 30);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d inserts (%0d refused on a full store), %0d deletes (%0d absent keys),",
             cmd_count[CMD_INSERT], full_drops, cmd_count[CMD_DELETE], absent_deletes);
    $display("%0d queries (%0d answered), %0d no-ops; peak occupancy %0d of %0d.",
             cmd_count[CMD_QUERY], query_hits, cmd_count[CMD_NOP], peak_occ, CAPACITY);
    if (mismatches == 0) begin
      $display("[ordered_multiset_successor_top] OK");
    end else begin
      $display("[ordered_multiset_successor_top] ERROR");
    end
    $finish;
  end

endmodule
